// ----- sv/tfd_pkg.sv -----
// ============================================================================
// tfd_pkg: shared types and constants for the tilt and fall detector
// widths of the angle, limit and counter fields, fall codes, register indexes
// ============================================================================
package tfd_pkg;

  localparam int ANGLE_BITS    = 13;
  localparam int LIMIT_BITS    = 12;
  localparam int HOLD_BITS     = 16;
  localparam int COUNT_BITS    = 16;
  localparam int DIR_BITS      = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // signed compare width: holds |angle|, a limit and twice either
  localparam int CMP_BITS = ((ANGLE_BITS > LIMIT_BITS) ? ANGLE_BITS : LIMIT_BITS) + 2;
  // counter versus hold compare width
  localparam int CNT_CMP_BITS = (COUNT_BITS > HOLD_BITS) ? COUNT_BITS : HOLD_BITS;

  typedef logic signed [ANGLE_BITS-1:0]   angle_t;
  typedef logic        [LIMIT_BITS-1:0]   limit_t;
  typedef logic        [HOLD_BITS-1:0]    hold_t;
  typedef logic        [COUNT_BITS-1:0]   count_t;
  typedef logic        [DIR_BITS-1:0]     dir_t;
  typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic        [CFG_DATA_BITS-1:0] cfg_data_t;
  typedef logic signed [CMP_BITS-1:0]     cmp_t;
  typedef logic        [CNT_CMP_BITS-1:0] cnt_cmp_t;

  // fall direction codes
  localparam dir_t FALL_NONE     = 3'd0;
  localparam dir_t FALL_LEFT     = 3'd1;
  localparam dir_t FALL_RIGHT    = 3'd2;
  localparam dir_t FALL_BACKWARD = 3'd3;
  localparam dir_t FALL_FORWARD  = 3'd4;

  // configuration register indexes
  localparam cfg_idx_t CFG_ROLL_LIMIT  = 2'd0;
  localparam cfg_idx_t CFG_PITCH_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_HOLD_TICKS  = 2'd2;
  localparam cfg_idx_t CFG_SERVO_CUT   = 2'd3;

  // register reset values
  localparam limit_t ROLL_LIMIT_RST  = 12'd800;
  localparam limit_t PITCH_LIMIT_RST = 12'd880;
  localparam hold_t  HOLD_TICKS_RST  = 16'd50;

endpackage

// ----- sv/tfd_if.sv -----
// ============================================================================
// tfd_in_if / tfd_out_if: valid/ready channels of the tilt and fall detector
// sensor tick channel and result channel, each with source and sink modports
// ============================================================================
interface tfd_in_if;
  import tfd_pkg::*;

  logic   valid;
  logic   ready;
  angle_t roll_angle;
  angle_t pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

interface tfd_out_if;
  import tfd_pkg::*;

  logic valid;
  logic ready;
  logic tilt_now;
  dir_t fall_direction;
  logic servo_off;
  logic motion_accept;

  modport source (output valid, output tilt_now, output fall_direction,
                  output servo_off, output motion_accept, input ready);
  modport sink   (input valid, input tilt_now, input fall_direction,
                  input servo_off, input motion_accept, output ready);
endinterface

// ----- sv/tilt_fall_detector_core.sv -----
// ============================================================================
// tilt_fall_detector_core: tilt flag, fall direction and servo-off latch
// per sensor tick: compares roll/pitch against limits, counts ticks beyond
// a limit, latches servo off on a new tilt event, flags recovery
// ============================================================================
// an input transfer goes into the input register, then into the result register
// throughput: one tick per cycle unless results stall; the single decision stage
//   between the registers updates the detector state in the cycle an item passes it
// the result register frees its slot in the same cycle it is taken, so a
//   stalled result blocks input only once both registers are full
// reset (rst_n low, synchronous): pipeline empty, counter, fall code and
//   servo-off latch cleared, registers back to their default values
module tilt_fall_detector_core (
  input  logic               clk,
  input  logic               rst_n,
  tfd_in_if.sink             in_ch,
  tfd_out_if.source          out_ch,
  input  logic               cfg_we,
  input  tfd_pkg::cfg_idx_t  cfg_index,
  input  tfd_pkg::cfg_data_t cfg_data
);
  import tfd_pkg::*;

  // configuration registers
  limit_t roll_limit_r;
  limit_t pitch_limit_r;
  hold_t  hold_ticks_r;
  logic   servo_cut_r;

  // input stage
  logic   in_valid_r;
  angle_t roll_r;
  angle_t pitch_r;

  // detector state
  count_t beyond_cnt_r, beyond_cnt_nxt;
  dir_t   fall_code_r, fall_code_nxt;
  logic   prev_cut_r;
  logic   servo_off_r, servo_off_nxt;

  // result stage
  logic   out_valid_r;
  logic   tilt_r;
  dir_t   dir_r;
  logic   servo_r;
  logic   accept_r;

  // datapath
  cmp_t   roll_x, pitch_x, rl_x, pl_x, abs_roll, abs_pitch;
  logic   tilt_now, cut_req, accept_now;
  dir_t   zone_code;
  count_t cnt_inc;

  logic   out_free, advance;

  // handshake: result slot frees when empty or being taken this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.tilt_now       = tilt_r;
  assign out_ch.fall_direction = dir_r;
  assign out_ch.servo_off      = servo_r;
  assign out_ch.motion_accept  = accept_r;

  // configuration writes, low bits of each register kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_limit_r  <= ROLL_LIMIT_RST;
      pitch_limit_r <= PITCH_LIMIT_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
      servo_cut_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROLL_LIMIT:  roll_limit_r  <= cfg_data[LIMIT_BITS-1:0];
        CFG_PITCH_LIMIT: pitch_limit_r <= cfg_data[LIMIT_BITS-1:0];
        CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_data[HOLD_BITS-1:0];
        CFG_SERVO_CUT:   servo_cut_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decision logic on the registered angles
  always_comb begin
    // widen to a common signed compare width
    roll_x    = cmp_t'(roll_r);
    pitch_x   = cmp_t'(pitch_r);
    rl_x      = cmp_t'(roll_limit_r);
    pl_x      = cmp_t'(pitch_limit_r);
    abs_roll  = roll_x[CMP_BITS-1]  ? -roll_x  : roll_x;
    abs_pitch = pitch_x[CMP_BITS-1] ? -pitch_x : pitch_x;

    // tilt: magnitude strictly above limit
    tilt_now = (abs_roll > rl_x) || (abs_pitch > pl_x);

    // servo-off latch sets on a rising cut request
    cut_req       = servo_cut_r && tilt_now;
    servo_off_nxt = servo_off_r || (cut_req && !prev_cut_r);

    // zone priority: roll+, roll-, pitch+, pitch-
    priority if (roll_x >= rl_x)   zone_code = FALL_LEFT;
    else if (roll_x <= -rl_x)      zone_code = FALL_RIGHT;
    else if (pitch_x >= pl_x)      zone_code = FALL_BACKWARD;
    else if (pitch_x <= -pl_x)     zone_code = FALL_FORWARD;
    else                           zone_code = FALL_NONE;

    // saturating counter
    cnt_inc = (&beyond_cnt_r) ? beyond_cnt_r : beyond_cnt_r + count_t'(1);

    beyond_cnt_nxt = beyond_cnt_r;
    fall_code_nxt  = fall_code_r;
    accept_now     = 1'b0;
    if (zone_code != FALL_NONE) begin
      beyond_cnt_nxt = cnt_inc;
      if (cnt_cmp_t'(cnt_inc) > cnt_cmp_t'(hold_ticks_r)) begin
        fall_code_nxt = zone_code;
      end
    end else if (((abs_roll <<< 1) < rl_x) && ((abs_pitch <<< 1) < pl_x)) begin
      // recovered: both inside half limits
      beyond_cnt_nxt = '0;
      fall_code_nxt  = FALL_NONE;
      accept_now     = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      beyond_cnt_r <= '0;
      fall_code_r  <= FALL_NONE;
      prev_cut_r   <= 1'b0;
      servo_off_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        beyond_cnt_r <= beyond_cnt_nxt;
        fall_code_r  <= fall_code_nxt;
        prev_cut_r   <= cut_req;
        servo_off_r  <= servo_off_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      roll_r  <= in_ch.roll_angle;
      pitch_r <= in_ch.pitch_angle;
    end
    if (advance) begin
      tilt_r   <= tilt_now;
      dir_r    <= fall_code_nxt;
      servo_r  <= servo_off_nxt;
      accept_r <= accept_now;
    end
  end

endmodule

// ----- sv/tfd_checker.sv -----
// ============================================================================
// tfd_checker: port-level checks for the tilt and fall detector
// result channel behavior over time, attached to the core by bind
// ============================================================================
module tfd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_tilt_now,
  input tfd_pkg::dir_t out_fall_direction,
  input logic          out_servo_off,
  input logic          out_motion_accept
);
  import tfd_pkg::*;

  // nothing shows on the result channel right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_tilt_now) && $stable(out_fall_direction) &&
       $stable(out_servo_off) && $stable(out_motion_accept)))
    else $error("stalled result changed");

  // servo-off latch never drops without reset
  a_servo_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_servo_off) |=> !(out_valid && !out_servo_off))
    else $error("servo off dropped");

  // recovery clears the fall direction and excludes tilt
  a_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motion_accept) |->
      (out_fall_direction == FALL_NONE && !out_tilt_now))
    else $error("motion accept with fall or tilt");

endmodule

bind tilt_fall_detector_core tfd_checker u_tfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_tilt_now       (out_ch.tilt_now),
  .out_fall_direction (out_ch.fall_direction),
  .out_servo_off      (out_ch.servo_off),
  .out_motion_accept  (out_ch.motion_accept)
);

// ----- test/tb_top.sv -----
// ============================================================================
// tb_top: self-checking regression for tilt_fall_detector_core
// sensor ticks go in as random bursts while the result side stalls on its own
// pattern; an independent detector model predicts every result, which is
// compared field by field, and the thresholds are reprogrammed between phases
// ============================================================================
import tfd_pkg::*;

typedef struct packed {
  logic tilt_now;
  dir_t fall_direction;
  logic servo_off;
  logic motion_accept;
} tfd_result_t;

// where an angle sits relative to its limit
typedef enum int {BAND_INSIDE_HALF, BAND_BETWEEN, BAND_BEYOND} band_e;

// result sink behavior, redrawn at random by the receiver
typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_CADENCE, SINK_HEAVY} sink_mode_e;

class tfd_scoreboard;
  limit_t roll_lim;
  limit_t pitch_lim;
  hold_t  hold_lim;
  logic   cut_en;

  int     beyond_cnt;
  int     count_max;
  dir_t   fall_dir;
  logic   prev_cut;
  logic   servo_latch;

  tfd_result_t due_q[$];

  int errors;
  int reports;
  int ticks;
  int checked;
  int falls;
  int recoveries;
  int pinned;

  function new();
    roll_lim    = ROLL_LIMIT_RST;
    pitch_lim   = PITCH_LIMIT_RST;
    hold_lim    = HOLD_TICKS_RST;
    cut_en      = 1'b0;
    beyond_cnt  = 0;
    count_max   = (1 << COUNT_BITS) - 1;
    fall_dir    = FALL_NONE;
    prev_cut    = 1'b0;
    servo_latch = 1'b0;
    errors      = 0;
    reports     = 0;
    ticks       = 0;
    checked     = 0;
    falls       = 0;
    recoveries  = 0;
    pinned      = 0;
  endfunction

  // only the low bits of each register survive a write
  function void write_reg(cfg_idx_t idx, cfg_data_t val);
    case (idx)
      CFG_ROLL_LIMIT:  roll_lim  = val[LIMIT_BITS-1:0];
      CFG_PITCH_LIMIT: pitch_lim = val[LIMIT_BITS-1:0];
      CFG_HOLD_TICKS:  hold_lim  = val[HOLD_BITS-1:0];
      CFG_SERVO_CUT:   cut_en    = val[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  // one sensor tick transfer: update the detector state, queue the result
  function void note_tick(angle_t roll, angle_t pitch);
    int r, p, rl, pl, ar, ap;
    dir_t zone;
    logic tilt, cut;
    tfd_result_t res;
    r  = roll;
    p  = pitch;
    rl = roll_lim;
    pl = pitch_lim;
    ar = (r < 0) ? -r : r;
    ap = (p < 0) ? -p : p;

    tilt = (ar > rl) || (ap > pl);
    cut  = cut_en & tilt;
    if (cut && !prev_cut) servo_latch = 1'b1;
    prev_cut = cut;

    // zone priority: roll+, roll-, pitch+, pitch-
    if (r >= rl)       zone = FALL_LEFT;
    else if (r <= -rl) zone = FALL_RIGHT;
    else if (p >= pl)  zone = FALL_BACKWARD;
    else if (p <= -pl) zone = FALL_FORWARD;
    else               zone = FALL_NONE;

    res.motion_accept = 1'b0;
    if (zone != FALL_NONE) begin
      if (beyond_cnt < count_max) beyond_cnt++;
      else pinned++;
      if (beyond_cnt > int'(hold_lim)) fall_dir = zone;
    end else if (2 * ar < rl && 2 * ap < pl) begin
      fall_dir          = FALL_NONE;
      beyond_cnt        = 0;
      res.motion_accept = 1'b1;
      recoveries++;
    end
    if (fall_dir != FALL_NONE) falls++;

    res.tilt_now       = tilt;
    res.fall_direction = fall_dir;
    res.servo_off      = servo_latch;
    due_q.push_back(res);
    ticks++;
  endfunction

  function void flag(string what, logic [3:0] want, logic [3:0] got);
    errors++;
    if (reports < 40) begin
      reports++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function void check_result(tfd_result_t got);
    tfd_result_t want;
    checked++;
    if (due_q.size() == 0) begin
      errors++;
      if (reports < 40) begin
        reports++;
        $display({"%0t: result transfer with none expected, ",
                  "actual tilt=%0b dir=%0d servo=%0b accept=%0b"},
                 $time, got.tilt_now, got.fall_direction, got.servo_off, got.motion_accept);
      end
      return;
    end
    want = due_q.pop_front();
    if (got.tilt_now !== want.tilt_now)
      flag("tilt_now", want.tilt_now, got.tilt_now);
    if (got.fall_direction !== want.fall_direction)
      flag("fall_direction", want.fall_direction, got.fall_direction);
    if (got.servo_off !== want.servo_off)
      flag("servo_off", want.servo_off, got.servo_off);
    if (got.motion_accept !== want.motion_accept)
      flag("motion_accept", want.motion_accept, got.motion_accept);
  endfunction
endclass

module tb_top;
  localparam int ANGLE_MAX = 2880;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  tfd_in_if  in_ch ();
  tfd_out_if out_ch ();

  tfd_scoreboard sb;

  // sender burst state
  int burst_left = 1;
  bit steady     = 1'b0;   // no gaps between bursts in this phase
  int fed        = 0;
  int settings   = 1;      // the reset values count as the first setting

  // receiver stall state
  sink_mode_e sink_mode   = SINK_OPEN;
  int         sink_left   = 0;
  int         sink_phase  = 0;

  tilt_fall_detector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: the slowest legal run is far below this
  initial begin
    #20000000;
    $display("tilt_fall_detector_core regression: fail");
    $finish;
  end

  // receiver: its own stall pattern, independent of the sender
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      sink_left <= $urandom_range(16, 160);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_phase <= sink_phase + 1;
    case (sink_mode)
      SINK_OPEN:    out_ch.ready <= 1'b1;
      SINK_LIGHT:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      SINK_CADENCE: out_ch.ready <= ((sink_phase % 5) < 2);   // ready while the phase modulo 5 is below 2
      default:      out_ch.ready <= ($urandom_range(0, 9) < 4);
    endcase
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      sb.note_tick(in_ch.roll_angle, in_ch.pitch_angle);
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result({out_ch.tilt_now, out_ch.fall_direction,
                       out_ch.servo_off, out_ch.motion_accept});
  end

  // magnitude drawn from the requested band, clipped to the legal angle range
  function automatic angle_t band_angle(int lim, band_e band, int sign);
    int lo, hi, mag;
    case (band)
      BAND_INSIDE_HALF: begin lo = 0;             hi = (lim - 1) / 2; end
      BAND_BETWEEN:     begin lo = (lim + 1) / 2; hi = lim - 1;       end
      default:          begin lo = lim;           hi = ANGLE_MAX;     end
    endcase
    if (hi > ANGLE_MAX) hi = ANGLE_MAX;
    if (lo > ANGLE_MAX) lo = ANGLE_MAX;
    if (hi < lo) hi = lo;
    mag = $urandom_range(hi, lo);
    if (sign == 0) sign = ($urandom_range(0, 1) != 0) ? 1 : -1;
    return angle_t'(sign * mag);
  endfunction

  function automatic angle_t noise_angle();
    int v;
    v = $urandom_range(0, 2 * ANGLE_MAX);
    return angle_t'(v - ANGLE_MAX);
  endfunction

  // limits lean on the extremes now and then
  function automatic limit_t pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return limit_t'(ANGLE_MAX);
      2:       return limit_t'(1);
      default: return limit_t'($urandom_range(16, 2000));
    endcase
  endfunction

  function automatic hold_t pick_hold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return hold_t'($urandom);
      default: return hold_t'($urandom_range(1, 24));
    endcase
  endfunction

  // one tick transfer, then maybe a gap once the burst runs out
  task automatic feed_tick(angle_t r, angle_t p);
    in_ch.valid       <= 1'b1;
    in_ch.roll_angle  <= r;
    in_ch.pitch_angle <= p;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    fed++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  // stop sending and let every expected result come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  // reprogram all four registers while idle, sometimes with junk in the unused bits
  task automatic load_config(limit_t rl, limit_t pl, hold_t ht, logic cut);
    cfg_data_t junk;
    drain();
    junk = cfg_data_t'($urandom);
    if ($urandom_range(0, 1) != 0) junk = '0;
    put_reg(CFG_ROLL_LIMIT,  {junk[15:12], rl});
    put_reg(CFG_PITCH_LIMIT, {junk[11:8], pl});
    put_reg(CFG_HOLD_TICKS,  ht);
    put_reg(CFG_SERVO_CUT,   {junk[14:0], cut});
    cfg_we <= 1'b0;
    settings++;
  endtask

  // hold one zone, aiming past the hold count when it is under 30, then return inside the half limits
  task automatic fall_episode();
    int rl, pl, len;
    dir_t zone;
    angle_t r, p;
    rl   = sb.roll_lim;
    pl   = sb.pitch_lim;
    zone = dir_t'($urandom_range(FALL_LEFT, FALL_FORWARD));
    len  = (sb.hold_lim < 30) ? int'(sb.hold_lim) : $urandom_range(0, 30);
    len += $urandom_range(1, 5);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) begin
        // brief wobble back between the zones
        r = band_angle(rl, BAND_BETWEEN, 0);
        p = band_angle(pl, BAND_BETWEEN, 0);
      end else begin
        r = band_angle(rl, band_e'($urandom_range(0, 1)), 0);
        p = band_angle(pl, band_e'($urandom_range(0, 2)), 0);
        case (zone)
          FALL_LEFT:     r = band_angle(rl, BAND_BEYOND, 1);
          FALL_RIGHT:    r = band_angle(rl, BAND_BEYOND, -1);
          FALL_BACKWARD: p = band_angle(pl, BAND_BEYOND, 1);
          default:       p = band_angle(pl, BAND_BEYOND, -1);
        endcase
      end
      feed_tick(r, p);
    end
    repeat ($urandom_range(1, 3))
      feed_tick(band_angle(rl, BAND_INSIDE_HALF, 0), band_angle(pl, BAND_INSIDE_HALF, 0));
  endtask

  // mostly fall and recover episodes, some holding ticks, some noise
  task automatic random_phase(int n_ticks);
    int start;
    load_config(pick_limit(), pick_limit(), pick_hold(), 1'($urandom_range(0, 1)));
    steady = ($urandom_range(0, 4) == 0);
    start  = fed;
    while (fed - start < n_ticks) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: fall_episode();
        6, 7: repeat ($urandom_range(1, 6))
                feed_tick(band_angle(sb.roll_lim, BAND_BETWEEN, 0),
                          band_angle(sb.pitch_lim, band_e'($urandom_range(0, 1)), 0));
        default: repeat ($urandom_range(1, 6)) feed_tick(noise_angle(), noise_angle());
      endcase
    end
  endtask

  initial begin
    int guard;
    sb = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_ROLL_LIMIT;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.roll_angle  = '0;
    in_ch.pitch_angle = '0;
    out_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: limits 800/880, hold 50, servo cut off
    // strict tilt versus at-limit zone, both signs, half-limit edge, extremes
    feed_tick(0, 0);      feed_tick(800, 0);     feed_tick(801, 0);
    feed_tick(-800, 0);   feed_tick(-801, 0);    feed_tick(0, 880);
    feed_tick(0, -881);   feed_tick(399, 439);   feed_tick(400, 0);
    feed_tick(2880, -2880); feed_tick(-2880, 2880); feed_tick(0, 0);

    // short hold with servo cut: latch on first tilt, then zone priority
    load_config(800, 880, 2, 1'b1);
    feed_tick(0, 0);      feed_tick(0, -900);    feed_tick(0, -900);
    feed_tick(0, -900);   feed_tick(900, 900);   feed_tick(-900, 900);
    feed_tick(0, 900);    feed_tick(0, 0);

    // zero limits: every angle counts as beyond, no recovery possible
    load_config(0, 0, 0, 1'b0);
    feed_tick(0, 0);      feed_tick(-5, 0);      feed_tick(0, 1);
    feed_tick(0, -1);

    // maximum hold: the counter keeps climbing and no new fall is declared
    load_config(0, 0, '1, 1'($urandom_range(0, 1)));
    steady = 1'b1;
    repeat (16) feed_tick(noise_angle(), noise_angle());

    repeat (10) random_phase(95);

    // wind down: let the pipeline empty, bounded
    in_ch.valid <= 1'b0;
    for (guard = 0; guard < 2000 && sb.pending() != 0; guard++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results never delivered, expected 0 outstanding, actual %0d",
               $time, sb.pending());
    end

    $display("covered %0d tick transfers under %0d register settings, %0d results checked",
             sb.ticks, settings, sb.checked);
    $display("fall held on %0d ticks, %0d recoveries, counter pinned on %0d ticks, servo latch %0b",
             sb.falls, sb.recoveries, sb.pinned, sb.servo_latch);
    if (sb.errors == 0) begin
      $display("tilt_fall_detector_core regression: pass");
    end else begin
      $display("tilt_fall_detector_core regression: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/tfd_pkg.sv
sv/tfd_if.sv
sv/tilt_fall_detector_core.sv
sv/tfd_checker.sv
test/tb_top.sv
